// File: src/bhd_pkg.sv
// ----------------------------------------------------------------------------
// bhd_pkg
// Shared types, constants and helper functions of the 3x3 halftone block.
// ----------------------------------------------------------------------------
`default_nettype none

package bhd_pkg;

  // Default for the widest supported image row
  localparam int MAX_WIDTH_DEFAULT = 1024;

  // Image size registers
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int ROW_W      = 12;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 11'd1024;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 13'd1024;

  // Block sum store
  localparam int SUM_W = 12;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;

  // avg = floor(sum/n) reaches level k+1 when sum >= LEVEL_LIMIT[k] * n
  localparam logic [7:0] LEVEL_LIMIT [9] = '{8'd25, 8'd51, 8'd77, 8'd103, 8'd129,
                                             8'd155, 8'd181, 8'd207, 8'd233};

  // Cells turn white in this order as the level rises
  localparam logic [3:0] FILL_BIT [9] = '{4'd4, 4'd3, 4'd5, 4'd7, 4'd2,
                                          4'd6, 4'd0, 4'd8, 4'd1};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [10:0] block_row;
    logic [8:0]  block_col;
    logic [3:0]  level;
    logic [8:0]  dot_pattern;
    logic        last_block;
  } res_t;

  // One classified pixel, handed from front to back
  typedef struct packed {
    logic [7:0]  grey;
    logic        first;       // opens a new block: sum restarts
    logic        emit;        // closes a block: a result follows
    logic [3:0]  pix_count;   // in-image pixels of the block, 1..9
    logic [10:0] block_row;
    logic [8:0]  block_col;
    logic        last_block;
  } cmd_t;

  function automatic logic [3:0] level_of(input logic [SUM_W-1:0] sum,
                                          input logic [3:0] n);
    logic [3:0] lvl;
    lvl = '0;
    for (int k = 0; k < 9; k++) begin
      if (sum >= SUM_W'(LEVEL_LIMIT[k]) * SUM_W'(n)) begin
        lvl = lvl + 4'd1;
      end
    end
    return lvl;
  endfunction

  function automatic logic [8:0] pattern_of(input logic [3:0] lvl);
    logic [8:0] p;
    p = '0;
    for (int k = 0; k < 9; k++) begin
      if (4'(k) < lvl) begin
        p[FILL_BIT[k]] = 1'b1;
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: src/block_halftone_dither.sv
// ----------------------------------------------------------------------------
// block_halftone_dither
// 3x3 block ordered halftone: raster RGB pixels in, one level and dot
// pattern per 3x3 block out.
//
//   channel  direction  handshake            payload
//   in_      in         in_valid/in_ready    pix_t (red, green, blue)
//   out_     out        out_valid/out_ready  res_t (block, level, pattern)
//   cfg_     in         cfg_we               cfg_index, cfg_data
//
// One pixel per cycle sustained while out_ready does not stall; a pixel's
// result reaches the result register through the queue, then the sum RAM read,
// then update and quantise, and out_valid rises together with it.
// The block sum RAM does one read and one write per cycle; a same-column
// update in the following cycle is forwarded around the RAM.
// Sum RAM has no clearing pass: each block overwrites its entry first.
// A stalled out_ready holds the back end; the four-entry command queue
// then fills and in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module block_halftone_dither
  import bhd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire pix_t                  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output res_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_DEPTH = (MAX_WIDTH + 2) / 3;
  localparam int BC_W      = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int QW        = $bits(cmd_t) + BC_W;

  logic            push;
  cmd_t            push_cmd;
  logic [BC_W-1:0] push_addr;
  logic            full;
  logic            pop;
  logic            empty;
  logic [QW-1:0]   pop_data;
  cmd_t            pop_cmd;
  logic [BC_W-1:0] pop_addr;

  bhd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (in_valid),
    .pix_ready (in_ready),
    .pix       (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (push),
    .cmd       (push_cmd),
    .cmd_addr  (push_addr),
    .cmd_full  (full)
  );

  bhd_fifo #(
    .WIDTH (QW),
    .DEPTH (FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_addr, push_cmd}),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  assign pop_cmd  = pop_data[$bits(cmd_t)-1:0];
  assign pop_addr = pop_data[QW-1:$bits(cmd_t)];

  bhd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (empty),
    .cmd_pop   (pop),
    .cmd       (pop_cmd),
    .cmd_addr  (pop_addr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: src/bhd_ram.sv
// ----------------------------------------------------------------------------
// bhd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bhd_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 342,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/bhd_fifo.sv
// ----------------------------------------------------------------------------
// bhd_fifo
// Small register FIFO decoupling the pixel front from the block back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bhd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  assign full     = (count_r == (AW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/bhd_front.sv
// ----------------------------------------------------------------------------
// bhd_front
// Holds the image size registers and raster position, converts each pixel
// to grey and classifies it for the block accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module bhd_front
  import bhd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int SUM_DEPTH = (MAX_WIDTH + 2) / 3,
  localparam int BC_W      = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  pix_valid,
  output logic                       pix_ready,
  input  wire pix_t                  pix,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       cmd_push,
  output cmd_t                       cmd,
  output logic      [BC_W-1:0]       cmd_addr,
  input  wire logic                  cmd_full
);

  logic [IMG_W_W-1:0] image_width_r;
  logic [IMG_H_W-1:0] image_height_r;
  logic [ROW_W-1:0]   row_r;
  logic [1:0]         row_mod_r;
  logic [10:0]        block_row_r;
  logic [COL_W-1:0]   col_r;
  logic [1:0]         col_mod_r;
  logic [BC_W-1:0]    block_col_r;

  logic [13:0]        width_ext;
  logic [13:0]        height_ext;
  logic [COL_W-1:0]   last_col_idx;
  logic [ROW_W-1:0]   last_row_idx;
  logic               at_last_col;
  logic               at_last_row;
  logic [9:0]         rgb_sum;
  logic [19:0]        grey_prod;
  logic               accept;

  assign pix_ready = !cmd_full;
  assign accept    = pix_valid && pix_ready;
  assign cmd_push  = accept;

  // Effective size: zero counts as one, oversize saturates
  assign width_ext  = 14'(image_width_r);
  assign height_ext = 14'(image_height_r);

  always_comb begin
    if (width_ext == '0) begin
      last_col_idx = '0;
    end else if (width_ext > 14'(MAX_WIDTH)) begin
      last_col_idx = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col_idx = COL_W'(width_ext - 14'd1);
    end
    if (height_ext == '0) begin
      last_row_idx = '0;
    end else if (height_ext > 14'(MAX_HEIGHT)) begin
      last_row_idx = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row_idx = ROW_W'(height_ext - 14'd1);
    end
  end

  assign at_last_col = (col_r == last_col_idx);
  assign at_last_row = (row_r == last_row_idx);

  // floor(s/3) as s*683 >> 11, exact for s <= 765
  assign rgb_sum   = 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
  assign grey_prod = 20'(rgb_sum) * 20'd683;

  always_comb begin
    cmd.grey       = grey_prod[18:11];
    cmd.first      = (row_mod_r == 2'd0) && (col_mod_r == 2'd0);
    cmd.emit       = (row_mod_r == 2'd2 || at_last_row) &&
                     (col_mod_r == 2'd2 || at_last_col);
    cmd.pix_count  = 4'((4'(row_mod_r) + 4'd1) * (4'(col_mod_r) + 4'd1));
    cmd.block_row  = block_row_r;
    cmd.block_col  = 9'(block_col_r);
    cmd.last_block = at_last_row && at_last_col;
    cmd_addr       = block_col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RESET;
      image_height_r <= IMAGE_HEIGHT_RESET;
      row_r          <= '0;
      row_mod_r      <= '0;
      block_row_r    <= '0;
      col_r          <= '0;
      col_mod_r      <= '0;
      block_col_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
      // any write restarts the image
      row_r       <= '0;
      row_mod_r   <= '0;
      block_row_r <= '0;
      col_r       <= '0;
      col_mod_r   <= '0;
      block_col_r <= '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_r       <= '0;
        col_mod_r   <= '0;
        block_col_r <= '0;
        if (at_last_row) begin
          row_r       <= '0;
          row_mod_r   <= '0;
          block_row_r <= '0;
        end else begin
          row_r <= row_r + 1'b1;
          if (row_mod_r == 2'd2) begin
            row_mod_r   <= '0;
            block_row_r <= block_row_r + 1'b1;
          end else begin
            row_mod_r <= row_mod_r + 1'b1;
          end
        end
      end else begin
        col_r <= col_r + 1'b1;
        if (col_mod_r == 2'd2) begin
          col_mod_r   <= '0;
          block_col_r <= block_col_r + 1'b1;
        end else begin
          col_mod_r <= col_mod_r + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/bhd_back.sv
// ----------------------------------------------------------------------------
// bhd_back
// Read-modify-write of the per-block-column sums, quantising of finished
// blocks and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bhd_back
  import bhd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int SUM_DEPTH = (MAX_WIDTH + 2) / 3,
  localparam int BC_W      = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_empty,
  output logic                 cmd_pop,
  input  wire cmd_t            cmd,
  input  wire logic [BC_W-1:0] cmd_addr,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output res_t                 out_data
);

  logic             s1_valid_r;
  cmd_t             s1_cmd_r;
  logic [BC_W-1:0]  s1_addr_r;
  logic             fwd_hit_r;
  logic [SUM_W-1:0] fwd_data_r;
  logic             out_valid_r;
  res_t             out_data_r;

  logic [SUM_W-1:0] ram_rdata;
  logic [SUM_W-1:0] old_sum;
  logic [SUM_W-1:0] s1_sum;
  logic [3:0]       s1_level;
  logic             out_free;
  logic             s1_fire;

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (!s1_cmd_r.emit || out_free);
  assign cmd_pop  = !cmd_empty && (!s1_valid_r || s1_fire);

  // The write of the item ahead lands on the same edge as this read
  assign old_sum  = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign s1_sum   = s1_cmd_r.first ? SUM_W'(s1_cmd_r.grey)
                                   : old_sum + SUM_W'(s1_cmd_r.grey);
  assign s1_level = level_of(s1_sum, s1_cmd_r.pix_count);

  bhd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (SUM_DEPTH)
  ) u_sum_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_addr_r),
    .wdata (s1_sum),
    .re    (cmd_pop),
    .raddr (cmd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= s1_fire && (s1_addr_r == cmd_addr);
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire && s1_cmd_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_cmd_r   <= cmd;
      s1_addr_r  <= cmd_addr;
      fwd_data_r <= s1_sum;
    end
    if (s1_fire && s1_cmd_r.emit) begin
      out_data_r.block_row   <= s1_cmd_r.block_row;
      out_data_r.block_col   <= s1_cmd_r.block_col;
      out_data_r.level       <= s1_level;
      out_data_r.dot_pattern <= pattern_of(s1_level);
      out_data_r.last_block  <= s1_cmd_r.last_block;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for block_halftone_dither. Raster pixels go in over valid/ready,
// a scoreboard keeps its own grey sums per block column and predicts every
// 3x3 block result, and results are checked in order while both sides idle
// and stall at random. Image sizes run from one pixel to the widest row.
// ----------------------------------------------------------------------------

module tb_top;
  import bhd_pkg::*;

  localparam int SUM_ENTRIES   = (MAX_WIDTH_DEFAULT + 2) / 3;
  localparam int RANDOM_PIXELS = 1450;
  localparam int SETTLE_CYCLES = 10;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int GREY_STEPS [10] = '{0, 24, 25, 50, 51, 76, 77, 232, 233, 255};

  class halftone_scoreboard;
    localparam int BLACK_BELOW = 25;

    logic [IMG_W_W-1:0] img_w;
    logic [IMG_H_W-1:0] img_h;
    logic [ROW_W-1:0]   row_pos;
    logic [9:0]         col_pos;
    logic [SUM_W-1:0]   col_sums [SUM_ENTRIES];
    int                 level_top [8];
    int                 dot_order [9];
    res_t               due_q [$];
    int                 n_pixels;
    int                 n_blocks;
    int                 n_images;
    int                 n_bad;

    function new();
      img_w     = IMAGE_WIDTH_RESET;
      img_h     = IMAGE_HEIGHT_RESET;
      row_pos   = '0;
      col_pos   = '0;
      foreach (col_sums[i]) col_sums[i] = '0;
      // upper bound of the average for levels 1..8
      level_top = '{50, 76, 102, 128, 154, 180, 206, 232};
      // centre, mid-left, mid-right, bottom-mid, top-right, bottom-left,
      // top-left, bottom-right, top-mid
      dot_order = '{4, 3, 5, 7, 2, 6, 0, 8, 1};
      n_pixels  = 0;
      n_blocks  = 0;
      n_images  = 0;
      n_bad     = 0;
    endfunction

    function int eff_width();
      int w;
      w = (img_w == 0) ? 1 : int'(img_w);
      return (w > MAX_WIDTH_DEFAULT) ? MAX_WIDTH_DEFAULT : w;
    endfunction

    function int eff_height();
      int h;
      h = (img_h == 0) ? 1 : int'(img_h);
      return (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_IMAGE_WIDTH) begin
        img_w = val[IMG_W_W-1:0];
      end else if (idx == REG_IMAGE_HEIGHT) begin
        img_h = val[IMG_H_W-1:0];
      end
      // any write starts a fresh image
      row_pos = '0;
      col_pos = '0;
    endfunction

    function void note_pixel(pix_t px);
      int   w, h, row, col, bc, grey, sum, avg, lvl, k;
      res_t r;
      w = eff_width();
      h = eff_height();
      if (row_pos >= h || col_pos >= w) begin
        row_pos = '0;
        col_pos = '0;
      end
      row  = int'(row_pos);
      col  = int'(col_pos);
      bc   = col / 3;
      grey = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
      // first pixel of a block overwrites whatever the column entry held
      if (row % 3 == 0 && col % 3 == 0) begin
        sum = grey;
      end else begin
        sum = (int'(col_sums[bc]) + grey) % (1 << SUM_W);
      end
      col_sums[bc] = SUM_W'(sum);
      n_pixels++;

      if ((row % 3 == 2 || row == h - 1) && (col % 3 == 2 || col == w - 1)) begin
        avg = sum / ((row % 3 + 1) * (col % 3 + 1));
        if (avg < BLACK_BELOW) begin
          lvl = 0;
        end else begin
          lvl = 9;
          for (k = 7; k >= 0; k--) begin
            if (avg <= level_top[k]) lvl = k + 1;
          end
        end
        r             = '0;
        r.block_row   = 11'(row / 3);
        r.block_col   = 9'(col / 3);
        r.level       = 4'(lvl);
        for (k = 0; k < lvl; k++) r.dot_pattern[dot_order[k]] = 1'b1;
        r.last_block  = (row == h - 1) && (col == w - 1);
        due_q = {due_q, r};
      end

      if (col + 1 >= w) begin
        col_pos = '0;
        row_pos = (row + 1 >= h) ? '0 : ROW_W'(row + 1);
      end else begin
        col_pos = 10'(col + 1);
      end
    endfunction

    function void report(string what, res_t want, res_t got);
      n_bad++;
      if (n_bad <= 10) begin
        $display("%s: expected row %0d col %0d level %0d dots %03h last %0b", what,
                 want.block_row, want.block_col, want.level, want.dot_pattern,
                 want.last_block);
        $display("    got row %0d col %0d level %0d dots %03h last %0b",
                 got.block_row, got.block_col, got.level, got.dot_pattern,
                 got.last_block);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      n_blocks++;
      if (due_q.size() == 0) begin
        report("result with no transaction pending", '0, got);
        return;
      end
      want = due_q.pop_front();
      if (got.block_row !== want.block_row || got.block_col !== want.block_col ||
          got.level !== want.level || got.dot_pattern !== want.dot_pattern ||
          got.last_block !== want.last_block) begin
        report($sformatf("block result %0d mismatch", n_blocks), want, got);
      end
      if (want.last_block) n_images++;
    endfunction

    function void flush_leftovers();
      while (due_q.size() != 0) begin
        report("result never arrived", due_q.pop_front(), '0);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  pix_t                  in_data;
  logic                  out_valid;
  logic                  out_ready;
  res_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  halftone_scoreboard sb;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int hold_req        = 0;
  int cycles          = 0;
  int n_writes        = 0;
  int n_backpressure  = 0;

  block_halftone_dither i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Entered and left at a falling edge; the pixel is held until taken.
  task automatic send_pixel(input pix_t px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  // Let every expected block out, then give the pipeline time to empty of
  // pixels that close no block.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.due_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    sb.write_reg(idx, CFG_DATA_W'(val));
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_writes++;
  endtask

  // Receiver: checks at the rising edge, decides ready at the falling edge
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
      if (in_valid && !in_ready) n_backpressure++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("[block_halftone_dither] ERROR");
    $finish;
  end

  initial begin : stimulus
    int   phase, w, h, ew, eh, n_px, n_random, k, pix_lo, pix_hi, pick;
    pix_t px;

    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data  = '0;
    n_random  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset size is 1024 x 1024: top-left pixels close no block
    send_pixel('{8'd255, 8'd0, 8'd255});
    send_pixel('{8'd0, 8'd255, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255});
    wait_drain();

    // Zero sizes act as a 1x1 image: every pixel is a block, and each is the last
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    foreach (GREY_STEPS[i]) send_pixel('{8'(GREY_STEPS[i]), 8'(GREY_STEPS[i]),
                                          8'(GREY_STEPS[i])});
    send_pixel('{8'd255, 8'd255, 8'd254});
    send_pixel('{8'd255, 8'd0, 8'd0});
    wait_drain();

    // Partial 2x2 block, wrap into a second image, then restart it midway
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 2);
    repeat (6) send_pixel('{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255))});
    wait_drain();
    write_reg(REG_IMAGE_WIDTH, 2);
    repeat (4) send_pixel('{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255))});
    wait_drain();

    phase = 0;
    while (n_random < RANDOM_PIXELS) begin
      case (phase % 5)
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        3: begin send_idle_pct = 28; recv_stall_pct = 28; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase

      pick = 3;
      n_px = 0;
      case (phase)
        0: begin w = 1;    h = 1;    n_px = 80;   end
        2: begin w = 3;    h = 4096; n_px = 24;   end
        4: begin w = 1;    h = 8191; n_px = 40;   end  // height saturates
        5: begin w = 2047; h = 0;    n_px = 30;   end  // width saturates
        6: begin w = 1024; h = 1;    n_px = 1024; end  // every block column
        default: begin
          w    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                             : $urandom_range(1, 10);
          h    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
          pick = $urandom_range(0, 3);
        end
      endcase
      if (pick != 1) write_reg(REG_IMAGE_WIDTH, w);
      if (pick != 0) write_reg(REG_IMAGE_HEIGHT, h);
      ew = sb.eff_width();
      eh = sb.eff_height();
      if (n_px == 0) begin
        n_px = ew * eh * $urandom_range(1, 3);
        if (n_px > 240) n_px = 240;
        // cut short now and then: the next write restarts the image
        if ($urandom_range(0, 3) == 0) n_px = $urandom_range(1, n_px);
      end

      if (phase == 0) begin
        // receiver holds off while the sender keeps offering: block fills up
        @(posedge clk);
        hold_req = LONG_HOLD;
        @(negedge clk);
      end

      pix_lo = 0;
      pix_hi = 255;
      for (k = 0; k < n_px; k++) begin
        if (k % (ew * eh) == 0 || $urandom_range(0, 29) == 0) begin
          pix_lo = $urandom_range(0, 255);
          pix_hi = ($urandom_range(0, 2) == 0) ? 255 :
                   ((pix_lo + 16 > 255) ? 255 : pix_lo + 16);
          if ($urandom_range(0, 3) == 0) pix_lo = 0;
        end
        px.red   = 8'($urandom_range(pix_hi, pix_lo));
        px.green = 8'($urandom_range(pix_hi, pix_lo));
        px.blue  = 8'($urandom_range(pix_hi, pix_lo));
        send_pixel(px);
        n_random++;
        if ($urandom_range(0, 79) == 0) wait_drain();
      end
      wait_drain();
      phase++;
    end

    wait_drain();
    sb.flush_leftovers();
    $display("%0d pixels (%0d random) over %0d settings, %0d register writes, %0d blocks",
             sb.n_pixels, n_random, phase, n_writes, sb.n_blocks);
    $display("%0d complete images, sizes 1x1 to 1024 wide and 4096 high,",
             sb.n_images);
    $display("%0d cycles of input backpressure", n_backpressure);
    if (sb.n_bad == 0) begin
      $display("[block_halftone_dither] OK");
    end else begin
      $display("%0d mismatches", sb.n_bad);
      $display("[block_halftone_dither] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/bhd_pkg.sv
src/bhd_ram.sv
src/bhd_fifo.sv
src/bhd_front.sv
src/bhd_back.sv
src/block_halftone_dither.sv
test/tb_top.sv
